@@ sv/nfrg_pkg.sv @@
// nfrg_pkg: shared types and constants for the next-fit range grouper
// no dependencies; imported by every nfrg module and the top level
package nfrg_pkg;

  localparam int unsigned KeyW = 32;
  localparam int unsigned CountW = 32;
  localparam logic [CountW-1:0] MaxEntriesReset = 32'd2000000;

  // one accepted input transaction
  typedef struct packed {
    logic              final_item;
    logic [CountW-1:0] entry_count;
    logic [KeyW-1:0]   key_number;
  } item_t;

  // one emitted range
  typedef struct packed {
    logic              end_of_burst;
    logic              oversize;
    logic [CountW-1:0] range_total;
    logic [KeyW-1:0]   range_last;
    logic [KeyW-1:0]   range_first;
  } result_t;

  // all results caused by one item, in output order
  typedef struct packed {
    logic [1:0] count;
    result_t    res1;
    result_t    res0;
  } burst_t;

endpackage

@@ sv/nfrg_in_reg.sv @@
// nfrg_in_reg: input holding register on the slave side
// depends on nfrg_pkg for item_t
module nfrg_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_valid,
  output logic           s_ready,
  input  nfrg_pkg::item_t s_item,
  output logic           item_valid,
  output nfrg_pkg::item_t item,
  input  logic           advance
);
  import nfrg_pkg::*;

  // free when empty or when the held item moves on this cycle
  assign s_ready = !item_valid || advance;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_ready) begin
      item_valid <= s_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      item <= s_item;
    end
  end

endmodule

@@ sv/nfrg_core.sv @@
// nfrg_core: open-range state, maximum register and next-fit decision
// depends on nfrg_pkg for item_t, result_t, burst_t
module nfrg_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [nfrg_pkg::CountW-1:0]    cfg_wdata,
  input  nfrg_pkg::item_t                item,
  input  logic                           advance,
  output nfrg_pkg::burst_t               burst
);
  import nfrg_pkg::*;

  logic [CountW-1:0] max_entries;
  logic              range_open;
  logic [KeyW-1:0]   open_first_key;
  logic [KeyW-1:0]   open_last_key;
  logic [CountW-1:0] open_sum;

  logic              range_open_next;
  logic [KeyW-1:0]   open_first_key_next;
  logic [KeyW-1:0]   open_last_key_next;
  logic [CountW-1:0] open_sum_next;

  logic              over;
  logic [CountW:0]   sum_wide;
  logic              overflow;
  logic              flush_first;
  logic              emit_b;
  logic              extend;
  result_t           res_a;
  result_t           res_b;
  result_t           new_range;

  // maximum register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= MaxEntriesReset;
    end else if (cfg_we) begin
      max_entries <= cfg_wdata;
    end
  end

  // decision for the held item
  always_comb begin
    over        = item.entry_count > max_entries;
    sum_wide    = {1'b0, open_sum} + {1'b0, item.entry_count};
    overflow    = range_open && !over && (sum_wide > {1'b0, max_entries});
    flush_first = range_open && (over || overflow);
    extend      = range_open && !overflow;
    emit_b      = over || item.final_item;

    // open range as it stands
    res_a.range_first  = open_first_key;
    res_a.range_last   = open_last_key;
    res_a.range_total  = open_sum;
    res_a.oversize     = 1'b0;
    res_a.end_of_burst = !emit_b;

    // range after taking the item in
    new_range.range_first  = extend ? open_first_key : item.key_number;
    new_range.range_last   = item.key_number;
    new_range.range_total  = extend ? sum_wide[CountW-1:0] : item.entry_count;
    new_range.oversize     = 1'b0;
    new_range.end_of_burst = 1'b1;

    // second candidate: oversize key or flushed final range
    if (over) begin
      res_b.range_first  = item.key_number;
      res_b.range_last   = item.key_number;
      res_b.range_total  = item.entry_count;
      res_b.oversize     = 1'b1;
      res_b.end_of_burst = 1'b1;
    end else begin
      res_b = new_range;
    end

    // order results
    burst.count = {1'b0, flush_first} + {1'b0, emit_b};
    if (flush_first) begin
      burst.res0 = res_a;
      burst.res1 = res_b;
    end else begin
      burst.res0 = res_b;
      burst.res1 = res_b;
    end

    // next state
    if (emit_b) begin
      range_open_next     = 1'b0;
      open_first_key_next = '0;
      open_last_key_next  = '0;
      open_sum_next       = '0;
    end else begin
      range_open_next     = 1'b1;
      open_first_key_next = new_range.range_first;
      open_last_key_next  = new_range.range_last;
      open_sum_next       = new_range.range_total;
    end
  end

  // open-range state
  always_ff @(posedge clk) begin
    if (rst) begin
      range_open     <= 1'b0;
      open_first_key <= '0;
      open_last_key  <= '0;
      open_sum       <= '0;
    end else if (advance) begin
      range_open     <= range_open_next;
      open_first_key <= open_first_key_next;
      open_last_key  <= open_last_key_next;
      open_sum       <= open_sum_next;
    end
  end

  // a closed range never holds keys or a sum
  a_closed_clear: assert property (@(posedge clk) disable iff (rst)
    !range_open |-> (open_sum == '0 && open_first_key == '0))
    else $error("closed range holds stale state");

  // an oversize item always leaves no range open
  a_over_closes: assert property (@(posedge clk) disable iff (rst)
    (advance && over) |=> !range_open)
    else $error("range left open after oversize key");

  // a two-result burst always starts with the ordinary flushed range
  a_two_first: assert property (@(posedge clk) disable iff (rst)
    (burst.count == 2'd2) |-> (!burst.res0.oversize && !burst.res0.end_of_burst))
    else $error("bad first result of a pair");

endmodule

@@ sv/nfrg_out_buf.sv @@
// nfrg_out_buf: result register holding one item's burst, drained one per transaction
// depends on nfrg_pkg for result_t and burst_t
module nfrg_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  nfrg_pkg::burst_t  burst,
  input  logic              load_req,
  output logic              take,
  output logic              m_valid,
  input  logic              m_ready,
  output nfrg_pkg::result_t m_res
);
  import nfrg_pkg::*;

  result_t    slot0;
  result_t    slot1;
  logic [1:0] num;
  logic       load;

  // room for a new burst when empty or when the last result leaves now
  assign take    = (num == 2'd0) || (num == 2'd1 && m_ready);
  assign load    = load_req && take;
  assign m_valid = (num != 2'd0);
  assign m_res   = slot0;

  // result count
  always_ff @(posedge clk) begin
    if (rst) begin
      num <= 2'd0;
    end else if (load) begin
      num <= burst.count;
    end else if (m_valid && m_ready) begin
      num <= num - 2'd1;
    end
  end

  // result slots
  always_ff @(posedge clk) begin
    if (load) begin
      slot0 <= burst.res0;
      slot1 <= burst.res1;
    end else if (m_valid && m_ready && num == 2'd2) begin
      slot0 <= slot1;
    end
  end

  // count never beyond two
  a_num_range: assert property (@(posedge clk) disable iff (rst)
    num != 2'd3)
    else $error("result count out of range");

  // the last result held carries the burst end
  a_eob_last: assert property (@(posedge clk) disable iff (rst)
    (num == 2'd1) |-> slot0.end_of_burst)
    else $error("last result of burst without end mark");

  // a pending second result means the first is not the burst end
  a_eob_first: assert property (@(posedge clk) disable iff (rst)
    (num == 2'd2) |-> (!slot0.end_of_burst && slot1.end_of_burst))
    else $error("burst end marks out of order");

endmodule

@@ sv/next_fit_range_grouper_top.sv @@
// next_fit_range_grouper_top: next-fit grouping of (key, count) items into ranges
// depends on nfrg_pkg, nfrg_in_reg, nfrg_core, nfrg_out_buf
//
// channel  | dir | fields
// ---------+-----+--------------------------------------------------------------
// s_axis   | in  | tdata: key_number, entry_count; tlast: final_item
// m_axis   | out | tdata: range_first, range_last, range_total; tuser: oversize;
//          |     | tlast: end_of_burst
// cfg      | in  | cfg_we/cfg_wdata write max_entries
//
// an item is held in the input register, then moves into the result register; one item
// per cycle while each gives at most one result and m_tready is high. an item giving
// two results holds the input side until its second result leaves, as the single result
// register drains one transaction per cycle while m_tready is high.
// reset (rst, synchronous) empties both registers, closes the open range and
// sets max_entries to 2000000; m_tready low stalls back to s_tready.
module next_fit_range_grouper_top (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // key_number[31:0], entry_count[63:32]
  input  logic        s_tlast,   // final_item
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // range_first[31:0], range_last[63:32], range_total[95:64]
  output logic [0:0]  m_tuser,   // oversize[0]
  output logic        m_tlast    // end_of_burst
);
  import nfrg_pkg::*;

  item_t   s_item;
  item_t   item;
  logic    item_valid;
  logic    take;
  logic    advance;
  burst_t  burst;
  result_t m_res;

  // unpack slave transaction
  assign s_item.key_number  = s_tdata[31:0];
  assign s_item.entry_count = s_tdata[63:32];
  assign s_item.final_item  = s_tlast;

  // held item moves when the result register has room
  assign advance = item_valid && take;

  nfrg_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_tvalid),
    .s_ready    (s_tready),
    .s_item     (s_item),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance)
  );

  nfrg_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item),
    .advance   (advance),
    .burst     (burst)
  );

  nfrg_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .burst    (burst),
    .load_req (item_valid),
    .take     (take),
    .m_valid  (m_tvalid),
    .m_ready  (m_tready),
    .m_res    (m_res)
  );

  // pack master transaction
  assign m_tdata = {m_res.range_total, m_res.range_last, m_res.range_first};
  assign m_tuser = m_res.oversize;
  assign m_tlast = m_res.end_of_burst;

endmodule
